// File: rtl/core/atl_pkg.sv
// Shared constants and types for the ADC temperature linearizer core.
// Holds the breakpoint table, field widths and range status codes.
// No dependencies.
package atl_pkg;

  localparam int SAMPLE_W        = 10;
  localparam int TEMP_W          = 12;
  localparam int STATUS_W        = 2;
  localparam int TABLE_CAP       = 32;
  localparam int TIDX_W          = 5;
  localparam int FRAC_BITS_DEF   = 5;
  localparam int BREAKPOINTS_DEF = 13;
  localparam int BASE_DEG        = -25;
  localparam int STEP_DEG        = 5;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t RANGE_IN   = 2'd0;
  localparam status_t RANGE_LOW  = 2'd1;
  localparam status_t RANGE_HIGH = 2'd2;

  // Rising breakpoint table, padded past the thirteenth entry with full scale.
  localparam sample_t BP_TABLE [TABLE_CAP] = '{
    10'd75,   10'd100,  10'd131,  10'd169,  10'd214,  10'd265,  10'd322,
    10'd384,  10'd447,  10'd512,  10'd574,  10'd633,  10'd687,
    10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023,
    10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023,
    10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023
  };

endpackage

// File: rtl/core/adc_temperature_linearizer_core.sv
// Top level of the ADC temperature linearizer: pipelined table search,
// interpolation setup and a restoring divider, one quotient bit per stage.
// Depends on atl_pkg.

// Usage
// - Input channel: in_valid / in_stall carry one 10-bit ADC sample per beat.
//   A beat is taken at a rising edge with in_valid high and in_stall low.
// - Output channel: out_valid / out_stall carry the temperature in degrees
//   Celsius times 2^FRAC_BITS (12-bit two's complement, wrapped to 12 bits)
//   and a range status: in table, saturated low at -25 C, saturated high at
//   the last breakpoint's temperature.
// - Path: the beat's own edge loads the input register, then table search,
//   interpolation setup, FRAC_BITS+3 divider stages and output register.
// - Throughput: one beat per cycle while not stalled; every stage is
//   registered and carries its own valid bit, so the divider chain is the
//   depth, not the rate.
// - Stall: the whole pipeline holds while the output register is full and
//   out_stall is high; in_stall follows that condition, so no beat is lost or
//   repeated and the waiting result keeps its value.
// - Reset: rst_n (synchronous, active low) clears all valid bits; data
//   registers are left as they are. No configuration, no stored state.
module adc_temperature_linearizer_core #(
  parameter int FRAC_BITS   = atl_pkg::FRAC_BITS_DEF,
  parameter int BREAKPOINTS = atl_pkg::BREAKPOINTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  atl_pkg::sample_t                    in_adc_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [atl_pkg::TEMP_W-1:0]   out_temperature_q5,
  output atl_pkg::status_t                    out_range_status
);
  import atl_pkg::*;

  // Table size in use, clamped to between 2 and the table capacity
  localparam int N_BP  = (BREAKPOINTS < 2) ? 2 :
                         ((BREAKPOINTS > TABLE_CAP) ? TABLE_CAP : BREAKPOINTS);
  localparam int KW    = $clog2(TABLE_CAP + 1);
  // Quotient bits: the fraction never exceeds STEP_DEG << FRAC_BITS
  localparam int QW    = FRAC_BITS + 3;
  // Numerator: sample difference times the step scale
  localparam int NW    = SAMPLE_W + QW;
  // Whole degrees fit in 9 signed bits (up to 130 C)
  localparam int DW    = 9;
  localparam int TW    = DW + FRAC_BITS;
  localparam int XW    = (TW > TEMP_W) ? TW : TEMP_W;
  localparam logic [NW-1:0] SCALE = NW'(STEP_DEG << FRAC_BITS);

  // Pipeline advances unless a finished result waits on a stalled receiver
  logic advance;
  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  // Stage 1: input register
  logic    s1_valid_r;
  sample_t s1_sample_r;

  // Stage 2: search result
  logic          s2_valid_r;
  sample_t       s2_sample_r;
  logic [KW-1:0] s2_k_r;
  logic [KW-1:0] s2_k_nxt;

  // First breakpoint not below the sample; N_BP when the sample is above all
  always_comb begin
    s2_k_nxt = KW'(N_BP);
    for (int j = N_BP - 1; j >= 0; j--) begin
      if (s1_sample_r <= BP_TABLE[j]) begin
        s2_k_nxt = KW'(j);
      end
    end
  end

  // Divider chain: index 0 is the setup stage, index QW the last bit
  logic [QW:0]           dv_valid_r;
  logic [NW-1:0]         dv_rem_r    [QW+1];
  logic [SAMPLE_W-1:0]   dv_span_r   [QW+1];
  logic [QW-1:0]         dv_quo_r    [QW+1];
  logic signed [TW-1:0]  dv_base_r   [QW+1];
  status_t               dv_status_r [QW+1];

  // Stage 3: interpolation setup
  logic [TIDX_W-1:0]    st_idx;
  logic [TIDX_W-1:0]    st_lo_idx;
  sample_t              st_lo;
  sample_t              st_hi;
  logic [SAMPLE_W-1:0]  st_span;
  logic [SAMPLE_W-1:0]  st_diff;
  logic signed [DW-1:0] st_deg;
  logic [NW-1:0]        dv_rem_nxt0;
  logic [SAMPLE_W-1:0]  dv_span_nxt0;
  logic signed [TW-1:0] dv_base_nxt0;
  status_t              dv_status_nxt0;

  always_comb begin
    st_lo_idx      = s2_k_r[TIDX_W-1:0] - 1'b1;
    st_lo          = BP_TABLE[st_lo_idx];
    st_hi          = BP_TABLE[s2_k_r[TIDX_W-1:0]];
    st_span        = st_hi - st_lo;
    st_diff        = s2_sample_r - st_lo;
    st_idx         = st_lo_idx;
    dv_rem_nxt0    = '0;
    dv_span_nxt0   = SAMPLE_W'(1);
    dv_status_nxt0 = RANGE_IN;
    priority if (s2_k_r >= KW'(N_BP)) begin
      // Above the last breakpoint: saturate to its temperature
      st_idx         = TIDX_W'(N_BP - 1);
      dv_status_nxt0 = RANGE_HIGH;
    end else if (s2_k_r == '0) begin
      st_idx         = '0;
      dv_status_nxt0 = (s2_sample_r < BP_TABLE[0]) ? RANGE_LOW : RANGE_IN;
    end else if (st_span != '0) begin
      dv_rem_nxt0  = NW'(st_diff) * SCALE;
      dv_span_nxt0 = st_span;
    end else begin
      // Zero span: keep a zero fraction
      dv_rem_nxt0 = '0;
    end
    st_deg       = DW'(BASE_DEG + STEP_DEG * int'(st_idx));
    dv_base_nxt0 = {st_deg, {FRAC_BITS{1'b0}}};
  end

  // Restoring division, one quotient bit per stage, MSB first
  logic [NW:0]   dv_trial   [QW];
  logic [NW-1:0] dv_rem_nxt [QW];
  logic [QW-1:0] dv_quo_nxt [QW];

  always_comb begin
    for (int d = 0; d < QW; d++) begin
      dv_trial[d] = {1'b0, dv_rem_r[d]} - ({1'b0, NW'(dv_span_r[d])} << (QW - 1 - d));
      if (!dv_trial[d][NW]) begin
        dv_rem_nxt[d] = dv_trial[d][NW-1:0];
        dv_quo_nxt[d] = dv_quo_r[d] | (QW'(1) << (QW - 1 - d));
      end else begin
        dv_rem_nxt[d] = dv_rem_r[d];
        dv_quo_nxt[d] = dv_quo_r[d];
      end
    end
  end

  // Output stage: base plus fraction, wrapped to the port width
  logic signed [TW-1:0]     out_sum;
  logic signed [XW-1:0]     out_ext;
  logic                     out_valid_r;
  logic [TEMP_W-1:0]        out_temp_r;
  status_t                  out_status_r;

  assign out_sum = dv_base_r[QW] + $signed(TW'(dv_quo_r[QW]));
  assign out_ext = XW'(out_sum);

  // Valid bits: cleared by reset, advance with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      dv_valid_r  <= '0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r  <= in_valid;
      s2_valid_r  <= s1_valid_r;
      dv_valid_r  <= {dv_valid_r[QW-1:0], s2_valid_r};
      out_valid_r <= dv_valid_r[QW];
    end
  end

  // Data registers: no reset, hold on stall
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_sample_r    <= in_adc_sample;
      s2_sample_r    <= s1_sample_r;
      s2_k_r         <= s2_k_nxt;
      dv_rem_r[0]    <= dv_rem_nxt0;
      dv_span_r[0]   <= dv_span_nxt0;
      dv_quo_r[0]    <= '0;
      dv_base_r[0]   <= dv_base_nxt0;
      dv_status_r[0] <= dv_status_nxt0;
      for (int d = 0; d < QW; d++) begin
        dv_rem_r[d+1]    <= dv_rem_nxt[d];
        dv_span_r[d+1]   <= dv_span_r[d];
        dv_quo_r[d+1]    <= dv_quo_nxt[d];
        dv_base_r[d+1]   <= dv_base_r[d];
        dv_status_r[d+1] <= dv_status_r[d];
      end
      out_temp_r   <= out_ext[TEMP_W-1:0];
      out_status_r <= dv_status_r[QW];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_temperature_q5 = out_temp_r;
  assign out_range_status   = out_status_r;

  // Checks
  localparam logic signed [XW-1:0] TEMP_LO_X =
    XW'(BASE_DEG * (1 << FRAC_BITS));
  localparam logic signed [XW-1:0] TEMP_HI_X =
    XW'((BASE_DEG + STEP_DEG * (N_BP - 1)) * (1 << FRAC_BITS));

  a_sat_high: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == RANGE_HIGH) |-> out_temp_r == TEMP_HI_X[TEMP_W-1:0])
    else $error("high saturation gives wrong temperature");

  a_sat_low: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == RANGE_LOW) |-> out_temp_r == TEMP_LO_X[TEMP_W-1:0])
    else $error("low saturation gives wrong temperature");

  a_frac_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dv_valid_r[QW] |-> (NW'(dv_quo_r[QW]) <= SCALE))
    else $error("interpolation fraction exceeds one step");

  a_hold_stage1: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |=> (s1_valid_r && $stable(s1_sample_r)))
    else $error("input stage changed during stall");

endmodule
